/* rtl/core/rcbp_pkg.sv */
// Shared types and constants for the reference-counted buffer pool.
// Used by every module under rtl/core except rcbp_ram; depends on nothing.
`timescale 1ns / 1ps

package rcbp_pkg;

    localparam int NUM_SLOTS   = 64;
    localparam int NUM_GROUPS  = 4;
    localparam int COUNT_WIDTH = 16;
    localparam int REG_COUNT   = 4;

    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int REG_IDX_W   = $clog2(REG_COUNT);
    localparam int GROUP_REG_W = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int OPCODE_W    = 2;
    localparam int GROUP_W     = 2;
    localparam int SLOT_IDX_W  = 6;
    localparam int STATUS_W    = 3;
    localparam int BOUND_W     = (SLOT_W + 1 > 9) ? SLOT_W + 1 : 9;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_INC   = 2'd1,
        OP_DEC   = 2'd2,
        OP_CLEAR = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_NO_FREE       = 3'd1,
        ST_UNKNOWN_GROUP = 3'd2,
        ST_BAD_SLOT      = 3'd3,
        ST_UNDERFLOW     = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/core/rcbp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module rcbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/rcbp_ctrl.sv */
// Request sequencer for the buffer pool: capture, then update and post result.
// Depends on rcbp_pkg.
`timescale 1ns / 1ps

module rcbp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rcbp_pkg::dp_stat_t stat,
    output rcbp_pkg::dp_cmd_t  cmd
);
    import rcbp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            S_EXEC: begin
                cmd.commit = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/rcbp_datapath.sv */
// Datapath: group registers, zero flags, count memory, free-slot search, result.
// Depends on rcbp_pkg and rcbp_ram.
`timescale 1ns / 1ps

module rcbp_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  rcbp_pkg::dp_cmd_t                cmd,
    output rcbp_pkg::dp_stat_t               stat,
    input  logic [rcbp_pkg::OPCODE_W-1:0]    s_opcode,
    input  logic [rcbp_pkg::GROUP_W-1:0]     s_group_id,
    input  logic [rcbp_pkg::SLOT_IDX_W-1:0]  s_slot_index,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rcbp_pkg::STATUS_W-1:0]    m_status,
    output logic [rcbp_pkg::SLOT_IDX_W-1:0]  m_granted_slot,
    input  logic                             cfg_valid,
    input  logic [rcbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rcbp_pkg::GROUP_REG_W-1:0] cfg_data
);
    import rcbp_pkg::*;

    logic [GROUP_REG_W-1:0] group_slots_reg [REG_COUNT];

    opcode_t                op_reg;
    logic [SLOT_IDX_W-1:0]  slot_reg;
    logic [BOUND_W-1:0]     base_reg;
    logic [BOUND_W-1:0]     end_reg;
    logic                   group_bad_reg;

    logic [BOUND_W-1:0]     base_sum;
    logic [BOUND_W-1:0]     end_sum;
    logic                   group_bad;

    logic [NUM_SLOTS-1:0]   zero_flag_reg;
    logic [NUM_SLOTS-1:0]   zero_flag_next;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    status_t                m_status_reg;
    status_t                m_status_next;
    logic [SLOT_IDX_W-1:0]  m_granted_slot_reg;
    logic [SLOT_IDX_W-1:0]  m_granted_slot_next;

    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic [SLOT_W-1:0]      ram_raddr;
    logic [COUNT_WIDTH-1:0] ram_rdata;

    logic [NUM_SLOTS-1:0]   free_vec;
    logic [NUM_SLOTS-1:0]   lowest_vec;
    logic                   hit;
    logic [SLOT_W-1:0]      hit_idx;
    logic [SLOT_W-1:0]      slot_addr;
    logic                   slot_bad;
    logic [COUNT_WIDTH-1:0] count_cur;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < REG_COUNT; g++) begin
                group_slots_reg[g] <= '0;
            end
        end else if (cfg_valid && (int'(cfg_index) < REG_COUNT)) begin
            group_slots_reg[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
        end
    end

    // group bounds for the incoming request
    always_comb begin
        base_sum = '0;
        for (int g = 0; g < REG_COUNT; g++) begin
            if (g < int'(s_group_id)) begin
                base_sum = base_sum + BOUND_W'(group_slots_reg[g]);
            end
        end
        end_sum   = base_sum + BOUND_W'(group_slots_reg[s_group_id[REG_IDX_W-1:0]]);
        group_bad = (int'(s_group_id) >= NUM_GROUPS) || (int'(s_group_id) >= REG_COUNT);
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg        <= opcode_t'(s_opcode);
            slot_reg      <= s_slot_index;
            base_reg      <= base_sum;
            end_reg       <= end_sum;
            group_bad_reg <= group_bad;
        end
    end

    // hold the read address on the captured slot while the update waits
    assign ram_raddr = cmd.capture ? SLOT_W'(s_slot_index) : SLOT_W'(slot_reg);

    rcbp_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_SLOTS)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // free-slot search over the zero flags
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            free_vec[i] = zero_flag_reg[i] && (BOUND_W'(i) >= base_reg)
                          && (BOUND_W'(i) < end_reg);
        end
        lowest_vec = free_vec & (~free_vec + NUM_SLOTS'(1));
        hit        = |free_vec;
        hit_idx    = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (lowest_vec[i]) begin
                hit_idx = hit_idx | SLOT_W'(i);
            end
        end
    end

    assign slot_addr = SLOT_W'(slot_reg);
    assign slot_bad  = int'(slot_reg) >= NUM_SLOTS;
    assign count_cur = zero_flag_reg[slot_addr] ? '0 : ram_rdata;

    always_comb begin
        zero_flag_next      = zero_flag_reg;
        ram_we              = 1'b0;
        ram_waddr           = slot_addr;
        ram_wdata           = count_cur;
        m_status_next       = ST_OK;
        m_granted_slot_next = '0;
        case (op_reg)
            OP_ALLOC: begin
                ram_waddr = hit_idx;
                ram_wdata = COUNT_WIDTH'(1);
                if (group_bad_reg) begin
                    m_status_next = ST_UNKNOWN_GROUP;
                end else if (hit) begin
                    ram_we                  = cmd.commit;
                    m_granted_slot_next     = SLOT_IDX_W'(hit_idx);
                    zero_flag_next[hit_idx] = 1'b0;
                end else begin
                    m_status_next = ST_NO_FREE;
                end
            end
            OP_INC: begin
                ram_wdata = count_cur + COUNT_WIDTH'(1);
                if (slot_bad) begin
                    m_status_next = ST_BAD_SLOT;
                end else if (count_cur != '1) begin
                    ram_we                    = cmd.commit;
                    zero_flag_next[slot_addr] = 1'b0;
                end
            end
            OP_DEC: begin
                ram_wdata = count_cur - COUNT_WIDTH'(1);
                if (slot_bad) begin
                    m_status_next = ST_BAD_SLOT;
                end else if (count_cur == '0) begin
                    m_status_next = ST_UNDERFLOW;
                end else begin
                    ram_we                    = cmd.commit;
                    zero_flag_next[slot_addr] = (count_cur == COUNT_WIDTH'(1));
                end
            end
            OP_CLEAR: begin
                zero_flag_next = '1;
            end
            default: begin
                m_status_next = ST_OK;
            end
        endcase
        if (!cmd.commit) begin
            zero_flag_next = zero_flag_reg;
        end
    end

    assign stat.out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_flag_reg <= '1;
            m_valid_reg   <= 1'b0;
        end else begin
            zero_flag_reg <= zero_flag_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_status_reg       <= m_status_next;
            m_granted_slot_reg <= m_granted_slot_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_granted_slot = m_granted_slot_reg;

    a_clear_frees_all: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && op_reg == OP_CLEAR) |=> (&zero_flag_reg))
        else $error("clear left a slot marked in use");

    a_grant_claims_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && op_reg == OP_ALLOC && !group_bad_reg && hit)
        |=> !zero_flag_reg[$past(hit_idx)])
        else $error("granted slot still marked free");

    a_grant_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_OK) |-> (m_granted_slot_reg == '0))
        else $error("nonzero granted slot on a failed request");

endmodule

/* rtl/core/refcounted_buffer_pool.sv */
// Reference-counted buffer pool: one count per slot, slots split into four groups whose
// sizes are set through the configuration port. Each request is handled in order: first
// capture it and read the slot count memory, then search the zero-flag vector or update
// the count and load the result register. A request can be accepted while the previous
// result still waits; an unaccepted result stalls the update cycle. Clear sets every zero
// flag in its update cycle, so there is no clearing pass after reset.
`timescale 1ns / 1ps

module refcounted_buffer_pool (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [rcbp_pkg::OPCODE_W-1:0]    s_opcode,
    input  logic [rcbp_pkg::GROUP_W-1:0]     s_group_id,
    input  logic [rcbp_pkg::SLOT_IDX_W-1:0]  s_slot_index,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rcbp_pkg::STATUS_W-1:0]    m_status,
    output logic [rcbp_pkg::SLOT_IDX_W-1:0]  m_granted_slot,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rcbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rcbp_pkg::GROUP_REG_W-1:0] cfg_data
);
    import rcbp_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    rcbp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rcbp_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_opcode       (s_opcode),
        .s_group_id     (s_group_id),
        .s_slot_index   (s_slot_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_granted_slot (m_granted_slot),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

endmodule

/* tb/tb_refcounted_buffer_pool.sv */
// Self-checking testbench for refcounted_buffer_pool: drives pool requests and group-size
// writes, predicts every status and granted slot from a shadow of the counts and layout.
// Depends on rcbp_pkg and the refcounted_buffer_pool RTL only.
`timescale 1ns / 1ps

module tb_refcounted_buffer_pool;
    import rcbp_pkg::*;

    typedef struct {
        status_t                 status;
        logic [SLOT_IDX_W-1:0]   slot;
    } pool_outcome_t;

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic [OPCODE_W-1:0]    s_opcode       = '0;
    logic [GROUP_W-1:0]     s_group_id     = '0;
    logic [SLOT_IDX_W-1:0]  s_slot_index   = '0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic [STATUS_W-1:0]    m_status;
    logic [SLOT_IDX_W-1:0]  m_granted_slot;
    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index      = '0;
    logic [GROUP_REG_W-1:0] cfg_data       = '0;

    logic [COUNT_WIDTH-1:0] slot_refs [NUM_SLOTS];
    logic [GROUP_REG_W-1:0] group_size [REG_COUNT];
    pool_outcome_t          awaited_outcomes [$];

    bit source_idles = 1'b1;
    bit sink_idles   = 1'b1;
    int sink_hold    = 0;
    int error_count  = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int grants_seen  = 0;
    int underflows_seen = 0;
    int no_free_seen = 0;

    refcounted_buffer_pool u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_group_id     (s_group_id),
        .s_slot_index   (s_slot_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_granted_slot (m_granted_slot),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic pool_outcome_t apply_pool_request(opcode_t op,
                                                         logic [GROUP_W-1:0] grp,
                                                         logic [SLOT_IDX_W-1:0] slot);
        pool_outcome_t res;
        int base;
        int s;
        res.status = ST_OK;
        res.slot   = '0;
        case (op)
            OP_ALLOC: begin
                if (grp >= NUM_GROUPS || grp >= REG_COUNT) begin
                    res.status = ST_UNKNOWN_GROUP;
                end else begin
                    base = 0;
                    for (int g = 0; g < grp; g++) base += int'(group_size[g]);
                    res.status = ST_NO_FREE;
                    for (int i = 0; i < int'(group_size[grp]); i++) begin
                        s = base + i;
                        if (s >= NUM_SLOTS) break;
                        if (slot_refs[s] == '0) begin
                            slot_refs[s] = COUNT_WIDTH'(1);
                            res.status   = ST_OK;
                            res.slot     = s[SLOT_IDX_W-1:0];
                            break;
                        end
                    end
                end
            end
            OP_INC: begin
                if (slot >= NUM_SLOTS) res.status = ST_BAD_SLOT;
                else if (slot_refs[slot] != {COUNT_WIDTH{1'b1}})
                    slot_refs[slot] = slot_refs[slot] + COUNT_WIDTH'(1);
            end
            OP_DEC: begin
                if (slot >= NUM_SLOTS) res.status = ST_BAD_SLOT;
                else if (slot_refs[slot] == '0) res.status = ST_UNDERFLOW;
                else slot_refs[slot] = slot_refs[slot] - COUNT_WIDTH'(1);
            end
            default: begin
                foreach (slot_refs[i]) slot_refs[i] = '0;
            end
        endcase
        return res;
    endfunction

    task automatic issue_request(opcode_t op, logic [GROUP_W-1:0] grp,
                                 logic [SLOT_IDX_W-1:0] slot);
        pool_outcome_t outcome;
        if (source_idles && $urandom_range(99) < 32) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_group_id   <= grp;
        s_slot_index <= slot;
        do @(posedge aclk); while (s_ready !== 1'b1);
        outcome = apply_pool_request(op, grp, slot);
        awaited_outcomes.insert(awaited_outcomes.size(), outcome);
        requests_sent++;
    endtask

    task automatic drain_pool();
        s_valid <= 1'b0;
        while (awaited_outcomes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_group_size(int idx, int value);
        drain_pool();
        cfg_valid <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data  <= value[GROUP_REG_W-1:0];
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        if (idx < REG_COUNT) group_size[idx] = value[GROUP_REG_W-1:0];
    endtask

    task automatic set_layout(int g0, int g1, int g2, int g3);
        set_group_size(0, g0);
        set_group_size(1, g1);
        set_group_size(2, g2);
        set_group_size(3, g3);
    endtask

    task automatic issue_random_request();
        int pick;
        int span;
        logic [SLOT_IDX_W-1:0] slot;
        opcode_t op;
        pick = $urandom_range(99);
        span = 0;
        for (int g = 0; g < REG_COUNT; g++) span += int'(group_size[g]);
        if (span > NUM_SLOTS) span = NUM_SLOTS;
        if (span > 0 && $urandom_range(3) != 0) slot = SLOT_IDX_W'($urandom_range(span - 1, 0));
        else slot = SLOT_IDX_W'($urandom_range(NUM_SLOTS - 1, 0));
        if (pick < 45) op = OP_ALLOC;
        else if (pick < 65) op = OP_INC;
        else if (pick < 97) op = OP_DEC;
        else op = OP_CLEAR;
        issue_request(op, GROUP_W'($urandom_range(3, 0)), slot);
    endtask

    task automatic test_empty_groups();
        for (int g = 0; g < 4; g++) issue_request(OP_ALLOC, GROUP_W'(g), '0);
        issue_request(OP_DEC, 0, 6'd0);
        issue_request(OP_INC, 0, 6'd63);
        issue_request(OP_DEC, 3, 6'd63);
    endtask

    task automatic test_directed_layout();
        set_layout(3, 0, 64, 127);
        // out-of-range register indexes must be ignored
        set_group_size(4, 0);
        set_group_size(7, 127);
        for (int i = 0; i < 4; i++) issue_request(OP_ALLOC, 0, '0);
        issue_request(OP_ALLOC, 1, '0);
        issue_request(OP_ALLOC, 2, '0);
        issue_request(OP_ALLOC, 3, 6'h3F);
        issue_request(OP_INC, 0, 6'd1);
        issue_request(OP_DEC, 0, 6'd0);
        issue_request(OP_DEC, 0, 6'd0);
        issue_request(OP_DEC, 0, 6'd1);
        issue_request(OP_CLEAR, 2, 6'd21);
        issue_request(OP_ALLOC, 0, '0);
        issue_request(OP_ALLOC, 2, '0);
    endtask

    task automatic test_count_walk();
        drain_pool();
        source_idles = 1'b0;
        sink_idles   = 1'b0;
        issue_request(OP_CLEAR, 0, '0);
        repeat (24) issue_request(OP_INC, 1, 6'd42);
        repeat (24) issue_request(OP_DEC, 2, 6'd42);
        issue_request(OP_DEC, 0, 6'd42);
        drain_pool();
        source_idles = 1'b1;
        sink_idles   = 1'b1;
    endtask

    task automatic test_random_layouts();
        set_layout(4, 6, 2, 8);
        repeat (250) issue_random_request();
        set_layout(64, 64, 64, 64);
        repeat (150) issue_random_request();
        set_layout($urandom_range(127, 0), $urandom_range(127, 0),
                   $urandom_range(127, 0), $urandom_range(127, 0));
        set_group_size($urandom_range(7, 4), $urandom_range(127, 0));
        repeat (150) issue_random_request();
        // hold both sides busy for a whole phase
        set_layout(16, 16, 16, 16);
        source_idles = 1'b0;
        sink_idles   = 1'b0;
        repeat (200) issue_random_request();
        source_idles = 1'b1;
        sink_idles   = 1'b1;
        set_layout(0, 1, 0, 3);
        repeat (200) issue_random_request();
    endtask

    task automatic test_output_backpressure();
        set_layout(8, 8, 8, 8);
        sink_hold = 250;
        repeat (24) issue_random_request();
    endtask

    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
            m_ready <= 1'b0;
        end else if (sink_idles) begin
            m_ready <= ($urandom_range(99) >= 32);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        pool_outcome_t want;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (awaited_outcomes.size() == 0) begin
                $display("%0t: unexpected result status %0d slot %0d",
                         $time, m_status, m_granted_slot);
                error_count++;
            end else begin
                want = awaited_outcomes.pop_front();
                results_checked++;
                if (want.status == ST_OK && m_granted_slot != 0) grants_seen++;
                if (want.status == ST_UNDERFLOW) underflows_seen++;
                if (want.status == ST_NO_FREE) no_free_seen++;
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_status);
                    error_count++;
                end
                if (m_granted_slot !== want.slot) begin
                    $display("%0t: granted_slot expected %0d actual %0d",
                             $time, want.slot, m_granted_slot);
                    error_count++;
                end
            end
        end
    end

    initial begin
        foreach (slot_refs[i]) slot_refs[i] = '0;
        foreach (group_size[i]) group_size[i] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_groups();
        test_directed_layout();
        test_count_walk();
        test_random_layouts();
        test_output_backpressure();
        drain_pool();
        repeat (10) @(posedge aclk);
        $display("Sent %0d requests, checked %0d results across several group layouts,",
                 requests_sent, results_checked);
        $display("with %0d nonzero grants, %0d underflows and %0d exhausted groups.",
                 grants_seen, underflows_seen, no_free_seen);
        if (error_count == 0) begin
            $display("refcounted_buffer_pool verification clean");
        end else begin
            $display("refcounted_buffer_pool verification failed");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("Timeout with %0d results still awaited", awaited_outcomes.size());
        $display("refcounted_buffer_pool verification failed");
        $finish;
    end

endmodule
